FILE: src/vtdi_pkg.sv
// Shared types, constants and helpers for the vertex tuple dedup indexer.
`timescale 1ns / 1ps
`default_nettype none
package vtdi_pkg;

	// Fixed field sizes
	localparam int ID_BITS        = 16;
	localparam int MAX_ATTRIBUTES = 4;
	localparam int CFG_BITS       = 3;
	localparam int LOCAL_BITS     = 8;
	localparam int SLOT_BITS      = 24;
	localparam int TUPLE_BITS     = ID_BITS * MAX_ATTRIBUTES;
	localparam int IN_DATA_BITS   = TUPLE_BITS;
	localparam int OUT_DATA_BITS  = LOCAL_BITS + ID_BITS + SLOT_BITS;
	localparam int OUT_USER_BITS  = 2;

	localparam int DEF_TABLE_DEPTH = 256;

	localparam logic [SLOT_BITS-1:0] SLOT_MAX  = {SLOT_BITS{1'b1}};
	localparam logic [CFG_BITS-1:0]  CFG_RESET = CFG_BITS'(1);

	// Bit positions in m_axis_tuser
	localparam int USER_IS_NEW   = 0;
	localparam int USER_OVERFLOW = 1;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} vtdi_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;     // latch a new corner, restart the scan
		logic advance;  // step the table scan by one entry
		logic commit;   // write the result, update table and counters
	} vtdi_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic hit;        // compared entry matches the corner
		logic exhausted;  // all stored entries compared, none matched
		logic out_free;   // output register can take a result
	} vtdi_sts_t;

	// Lanes that take part in the compare: count 0 acts as 1, large counts clamp
	function automatic logic [MAX_ATTRIBUTES-1:0] lane_mask(input logic [CFG_BITS-1:0] cnt);
		logic [MAX_ATTRIBUTES-1:0] m;
		int unsigned n;
		n = int'(cnt);
		if (n < 1) n = 1;
		if (n > MAX_ATTRIBUTES) n = MAX_ATTRIBUTES;
		for (int w = 0; w < MAX_ATTRIBUTES; w++) begin
			m[w] = (w < n);
		end
		return m;
	endfunction

endpackage
`default_nettype wire

FILE: src/vtdi_ctrl.sv
// Controller state machine: accepts a corner, runs the scan, commits the result.
`timescale 1ns / 1ps
`default_nettype none
module vtdi_ctrl
	import vtdi_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  vtdi_sts_t      sts,
	output vtdi_cmd_t      cmd
);

	vtdi_state_t state_q, state_nxt;
	logic        done;

	assign done = sts.hit | sts.exhausted;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (done && sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready    = 1'b0;
		cmd.load    = 1'b0;
		cmd.advance = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCAN: begin
				cmd.advance = ~done;
				cmd.commit  = done & sts.out_free;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

FILE: src/vtdi_datapath.sv
// Datapath: tuple table memory, scan pipeline, counters and output register.
`timescale 1ns / 1ps
`default_nettype none
module vtdi_datapath
	import vtdi_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_BITS-1:0]      cfg_wdata,
	input  wire logic [IN_DATA_BITS-1:0]  in_data,
	input  wire logic                     in_part_start,
	input  vtdi_cmd_t                     cmd,
	output vtdi_sts_t                     sts,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [OUT_DATA_BITS-1:0]      out_data,
	output logic [OUT_USER_BITS-1:0]      out_user
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	// Table storage, undefined until written
	logic [TUPLE_BITS-1:0]     mem [TABLE_DEPTH];

	logic [CFG_BITS-1:0]       attr_cnt_q;
	logic [TUPLE_BITS-1:0]     tuple_q;
	logic [MAX_ATTRIBUTES-1:0] mask_q;
	logic [CW-1:0]             count_q;
	logic [SLOT_BITS-1:0]      slot_q;
	logic [CW-1:0]             ptr_q;
	logic                      valid_s1;
	logic [CW-1:0]             idx_s1;
	logic [TUPLE_BITS-1:0]     rdata_s1;
	logic                      out_valid_q;
	logic [OUT_DATA_BITS-1:0]  out_data_q;
	logic [OUT_USER_BITS-1:0]  out_user_q;

	logic [MAX_ATTRIBUTES-1:0] lane_eq;
	logic                      full;
	logic                      ptr_live;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_cnt_q <= CFG_RESET;
		end else if (cfg_we) begin
			attr_cnt_q <= cfg_wdata;
		end
	end

	// Corner capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tuple_q <= in_data;
			mask_q  <= lane_mask(attr_cnt_q);
		end
	end

	// Scan pointer and compare stage
	assign ptr_live = (ptr_q < count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (cmd.load) begin
			ptr_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (cmd.advance) begin
			valid_s1 <= ptr_live;
			if (ptr_live) ptr_q <= ptr_q + CW'(1);
		end
	end

	// Memory read and write ports
	always_ff @(posedge clk) begin
		if (cmd.advance) begin
			rdata_s1 <= mem[ptr_q[AW-1:0]];
			idx_s1   <= ptr_q;
		end
		if (cmd.commit && !sts.hit && !full) begin
			mem[count_q[AW-1:0]] <= tuple_q;
		end
	end

	// Per-lane compare under the attribute mask
	always_comb begin
		for (int w = 0; w < MAX_ATTRIBUTES; w++) begin
			lane_eq[w] = ~mask_q[w] |
				(rdata_s1[w*ID_BITS +: ID_BITS] == tuple_q[w*ID_BITS +: ID_BITS]);
		end
	end

	assign full          = (count_q >= DEPTH_C);
	assign sts.hit       = valid_s1 & (&lane_eq);
	assign sts.exhausted = ~valid_s1 & ~ptr_live;
	assign sts.out_free  = ~out_valid_q | out_ready;

	// Entry count and global slot counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			slot_q  <= '0;
		end else if (cmd.load) begin
			if (in_part_start) count_q <= '0;
		end else if (cmd.commit && !sts.hit && !full) begin
			count_q <= count_q + CW'(1);
			if (slot_q != SLOT_MAX) slot_q <= slot_q + SLOT_BITS'(1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (sts.hit) begin
				out_data_q <= {SLOT_BITS'(0), tuple_q[ID_BITS-1:0], LOCAL_BITS'(idx_s1)};
				out_user_q <= '0;
			end else if (full) begin
				out_data_q <= {SLOT_BITS'(0), tuple_q[ID_BITS-1:0], LOCAL_BITS'(0)};
				out_user_q <= OUT_USER_BITS'(1) << USER_OVERFLOW;
			end else begin
				out_data_q <= {slot_q, tuple_q[ID_BITS-1:0], LOCAL_BITS'(count_q)};
				out_user_q <= OUT_USER_BITS'(1) << USER_IS_NEW;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

endmodule
`default_nettype wire

FILE: src/vertex_tuple_dedup_indexer.sv
// Vertex tuple dedup indexer: top level joining controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
// One corner is taken per request; its first attribute_count ids (1 to 4) are
// compared against each distinct tuple stored for the current material part,
// one stored tuple per cycle from a single-port table memory of TABLE_DEPTH
// entries. A match returns the earlier part-local index; a miss stores the
// tuple and hands out the next part-local index and global vertex slot, or,
// when the table is full, stores nothing and flags overflow. A miss scans
// every stored entry of the part, a hit stops at its match, and no new corner
// is taken until the scan ends. A finished result waits in an output register
// while the next corner is taken; a result that finds that register still
// occupied holds the scan until the receiver takes the older one. part_start
// clears the table at once; the user must write attribute_count only when the
// block is idle, not enforced by the block. No clearing pass follows reset.
module vertex_tuple_dedup_indexer
	import vtdi_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_BITS-1:0]      cfg_wdata,      // attribute_count
	input  wire logic                     s_axis_tvalid,
	output logic                          s_axis_tready,
	input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata,   // attr_id_0..attr_id_3
	input  wire logic                     s_axis_tuser,   // part_start
	output logic                          m_axis_tvalid,
	input  wire logic                     m_axis_tready,
	output logic [OUT_DATA_BITS-1:0]      m_axis_tdata,   // local_index, position_ref, vertex_slot
	output logic [OUT_USER_BITS-1:0]      m_axis_tuser    // is_new, overflow
);

	vtdi_cmd_t cmd;
	vtdi_sts_t sts;

	vtdi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	vtdi_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_data       (s_axis_tdata),
		.in_part_start (s_axis_tuser),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_data      (m_axis_tdata),
		.out_user      (m_axis_tuser)
	);

`ifndef NO_ASSERTIONS
	// A taken request puts the block into its scan
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("request accepted while a scan was starting");

	// Match and exhaustion are exclusive
	a_hit_xor_exhausted: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.hit && sts.exhausted))
		else $error("scan reports hit and exhaustion together");

	// A result is never both new and overflowed
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[USER_IS_NEW] && m_axis_tuser[USER_OVERFLOW]))
		else $error("result flagged new and overflow");

	// Overflow results carry zero index and slot
	a_overflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[USER_OVERFLOW]) |->
			(m_axis_tdata[LOCAL_BITS-1:0] == '0 &&
			 m_axis_tdata[OUT_DATA_BITS-1 -: SLOT_BITS] == '0))
		else $error("overflow result with nonzero index or slot");
`endif

endmodule
`default_nettype wire
